[rtl/core/lbp_pkg.sv]
// lbp_pkg: shared constants, types and register codes for the 3x3 pattern block
// used by every module under rtl/core; depends on nothing else
`timescale 1ns / 1ps

package lbp_pkg;

    // frame geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = COL_W + 1;
    localparam int FH_W       = ROW_W + 1;
    localparam int PEND_W     = COL_W + 1;

    // channels and samples
    localparam int NUM_LANES  = 3;
    localparam int PIX_W      = 8;
    localparam int CH_W       = 2;
    localparam int LINE_W     = NUM_LANES * PIX_W;
    localparam int ENTRY_W    = 2 * LINE_W;
    localparam int NBR_N      = 8;

    // stream and register port widths
    localparam int IN_DATA_W  = LINE_W;
    localparam int RES_BITS   = LINE_W + COL_W + ROW_W;
    localparam int OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - RES_BITS;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // register reset values
    localparam logic [FW_W-1:0] FW_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET  = FH_W'(480);
    localparam logic [CH_W-1:0] NCH_RESET = CH_W'(1);

    // request kinds on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // output buffer depth
    localparam logic [1:0] BUF_FULL = 2'd2;

    typedef logic [NBR_N-1:0][PIX_W-1:0] nbr_t;
    typedef logic [NUM_LANES-1:0][PIX_W-1:0] codes_t;
    typedef logic [2:0][2:0][LINE_W-1:0] win_t;

    // one result as it leaves the block
    typedef struct packed {
        logic             fend;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        codes_t           codes;
    } res_t;

    // request held between line store read and window update
    typedef struct packed {
        logic              pixel;
        logic [COL_W-1:0]  addr;
        logic [LINE_W-1:0] px;
        logic              emit;
        logic [NBR_N-1:0]  ok;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              fend;
    } s1_t;

endpackage

[rtl/core/lbp_line_store.sv]
// lbp_line_store: the two previous rows, one entry per column {centre row, row above}
// single write and single registered read with write-to-read bypass; uses lbp_pkg
`timescale 1ns / 1ps

module lbp_line_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [lbp_pkg::COL_W-1:0]  rd_addr,
    input  logic                       wr_en,
    input  logic [lbp_pkg::COL_W-1:0]  wr_addr,
    input  logic [lbp_pkg::ENTRY_W-1:0] wr_data,
    output logic [lbp_pkg::ENTRY_W-1:0] rd_data
);
    import lbp_pkg::*;

    logic [ENTRY_W-1:0] line_mem [MAX_WIDTH];
    logic [ENTRY_W-1:0] rd_q_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic               byp_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= line_mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // a read that meets a write to the same column takes the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

[rtl/core/lbp_lane.sv]
// lbp_lane: eight centre-versus-neighbour compares for one channel
// neighbours outside the frame count as zero; uses lbp_pkg
`timescale 1ns / 1ps

module lbp_lane (
    input  logic [lbp_pkg::PIX_W-1:0] centre,
    input  lbp_pkg::nbr_t             nbrs,
    input  logic [lbp_pkg::NBR_N-1:0] ok,
    output logic [lbp_pkg::PIX_W-1:0] code
);
    import lbp_pkg::*;

    // one bit per neighbour, masked neighbours compare as zero
    always_comb
    begin
        for (int b = 0; b < NBR_N; b++)
        begin
            code[b] = ok[b] ? (centre > nbrs[b]) : (centre != '0);
        end
    end

endmodule

[rtl/core/lbp_merge.sv]
// lbp_merge: joins the lane codes with position, clears unused channels,
// and holds results in a two-entry output buffer; uses lbp_pkg
`timescale 1ns / 1ps

module lbp_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  lbp_pkg::res_t                res_in,
    input  logic [lbp_pkg::CH_W-1:0]     nch,
    output logic                         space,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lbp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import lbp_pkg::*;

    res_t       merged;
    res_t       head_reg;
    res_t       skid_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    // clear codes of channels not in use
    always_comb
    begin
        merged = res_in;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (nch <= CH_W'(i))
            begin
                merged.codes[i] = '0;
            end
        end
    end

    assign pop   = (cnt_reg != 2'd0) && m_tready;
    assign space = (cnt_reg != BUF_FULL);

    // output buffer payload
    always_ff @(posedge clk)
    begin
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    head_reg <= merged;
                end
                else
                begin
                    skid_reg <= merged;
                end
            end
            2'b01:
            begin
                head_reg <= skid_reg;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    head_reg <= merged;
                end
                else
                begin
                    head_reg <= skid_reg;
                    skid_reg <= merged;
                end
            end
            default:
            begin
                head_reg <= head_reg;
            end
        endcase
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, head_reg.row, head_reg.col, head_reg.codes};
    assign m_tlast  = head_reg.fend;

    // a full buffer is never pushed
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == BUF_FULL) |-> !push)
        else $error("output buffer pushed while full");

    // count stays within two entries
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BUF_FULL)
        else $error("output buffer count out of range");

endmodule

[rtl/core/local_binary_pattern_3x3.sv]
// local_binary_pattern_3x3: top level, config registers, position counters, window
// instantiates lbp_line_store, lbp_lane and lbp_merge; uses lbp_pkg
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  s_*       | s_tvalid / s_tready        | s_tdata: chan_a, chan_b, chan_c; s_tuser: op
//  m_*       | m_tvalid / m_tready        | m_tdata: code_a..c, col, row; m_tlast: frame_end
//  apb       | psel / penable / pready=1  | paddr 4*index, pwdata / prdata 32 bits
//
// one request per cycle unless a full output buffer holds the read stage; a result passes
// the line store read, then the window update and compares, into the output buffer
// the first frame_width+1 pixels after reset or a register write give no result
// reset clears registers to 640x480, one channel; line store contents stay undefined
// a stall on m_* is absorbed by a two-entry output buffer before s_tready drops
`timescale 1ns / 1ps

module local_binary_pattern_3x3 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbp_pkg::APB_AW-1:0]     paddr,
    input  logic [lbp_pkg::APB_DW-1:0]     pwdata,
    output logic [lbp_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lbp_pkg::IN_DATA_W-1:0]  s_tdata,   // chan_a, chan_b, chan_c
    input  logic                           s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lbp_pkg::OUT_DATA_W-1:0] m_tdata,   // code_a, code_b, code_c, col, row
    output logic                           m_tlast    // frame_end
);
    import lbp_pkg::*;

    logic [FW_W-1:0]   fw_reg;
    logic [FH_W-1:0]   fh_reg;
    logic [CH_W-1:0]   nch_reg;
    logic [FW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [CH_W-1:0]   nch_eff;
    logic              cfg_wr;
    logic              cfg_restart;
    logic [1:0]        reg_idx;

    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [PEND_W-1:0] pending_reg;

    logic              accept;
    logic              is_drain;
    logic              has_pending;
    logic              shift0;
    logic              emit0;
    logic [FW_W-1:0]   in_col_inc;
    logic              in_wrap;
    logic [FH_W-1:0]   in_row_inc;
    logic [FW_W-1:0]   out_col_inc;
    logic              out_wrap;
    logic [FH_W-1:0]   out_row_inc;
    logic              out_row_wrap;
    logic [COL_W-1:0]  out_col_adv;
    logic [COL_W-1:0]  rd_addr;
    logic              ok_l;
    logic              ok_r;
    logic              ok_t;
    logic              ok_b;
    s1_t               s1_next;

    s1_t               s1_reg;
    logic              s1_valid_reg;
    logic              s1_go;
    logic              out_space;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    win_t              win_reg;
    win_t              win_next;
    codes_t            lane_codes;
    res_t              res;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // only a listed register restarts the pipeline
    assign cfg_restart = cfg_wr && (reg_idx <= REG_CHANNEL_COUNT);

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:   prdata = APB_DW'(fw_reg);
            REG_FRAME_HEIGHT:  prdata = APB_DW'(fh_reg);
            REG_CHANNEL_COUNT: prdata = APB_DW'(nch_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= FW_RESET;
            fh_reg  <= FH_RESET;
            nch_reg <= NCH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:   fw_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT:  fh_reg  <= pwdata[FH_W-1:0];
                REG_CHANNEL_COUNT: nch_reg <= pwdata[CH_W-1:0];
                default:           fw_reg  <= fw_reg;
            endcase
        end
    end

    // saturated geometry
    assign w_eff   = (fw_reg == '0) ? FW_W'(1) :
                     (fw_reg > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_reg;
    assign h_eff   = (fh_reg == '0) ? FH_W'(1) :
                     (fh_reg > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_reg;
    assign nch_eff = (nch_reg == '0) ? CH_W'(1) : nch_reg;

    // request decode and position arithmetic
    assign accept      = s_tvalid && s_tready;
    assign is_drain    = (s_tuser == OP_DRAIN);
    assign has_pending = (pending_reg != '0);
    assign shift0      = !is_drain || has_pending;
    assign emit0       = is_drain ? has_pending : (pending_reg > w_eff);

    assign in_col_inc  = {1'b0, in_col_reg} + FW_W'(1);
    assign in_wrap     = (in_col_inc >= w_eff);
    assign in_row_inc  = {1'b0, in_row_reg} + FH_W'(1);

    assign out_col_inc  = {1'b0, out_col_reg} + FW_W'(1);
    assign out_wrap     = (out_col_inc >= w_eff);
    assign out_row_inc  = {1'b0, out_row_reg} + FH_W'(1);
    assign out_row_wrap = (out_row_inc >= h_eff);
    assign out_col_adv  = out_wrap ? '0 : out_col_inc[COL_W-1:0];

    assign rd_addr = is_drain ? out_col_adv : in_col_reg;

    // frame-edge masks for the centre about to be emitted
    assign ok_l = (out_col_reg != '0);
    assign ok_r = !out_wrap;
    assign ok_t = (out_row_reg != '0);
    assign ok_b = !out_row_wrap;

    always_comb
    begin
        s1_next.pixel = !is_drain;
        s1_next.addr  = rd_addr;
        s1_next.px    = is_drain ? '0 : s_tdata;
        s1_next.emit  = emit0;
        s1_next.ok    = {ok_r && ok_b, ok_r, ok_r && ok_t, ok_b, ok_t,
                         ok_l && ok_b, ok_l, ok_l && ok_t};
        s1_next.col   = out_col_reg;
        s1_next.row   = out_row_reg;
        s1_next.fend  = out_wrap && out_row_wrap;
    end

    // position counters and pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else if (cfg_restart)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else if (accept && shift0)
        begin
            if (!is_drain)
            begin
                in_col_reg <= in_wrap ? '0 : in_col_inc[COL_W-1:0];
                if (in_wrap)
                begin
                    in_row_reg <= (in_row_inc >= h_eff) ? '0 : in_row_inc[ROW_W-1:0];
                end
                if (!emit0)
                begin
                    pending_reg <= pending_reg + PEND_W'(1);
                end
            end
            else
            begin
                pending_reg <= pending_reg - PEND_W'(1);
            end
            if (emit0)
            begin
                out_col_reg <= out_col_adv;
                if (out_wrap)
                begin
                    out_row_reg <= out_row_wrap ? '0 : out_row_inc[ROW_W-1:0];
                end
            end
        end
    end

    // read stage hand-off
    assign s1_go    = s1_valid_reg && (!s1_reg.emit || out_space);
    assign s_tready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= shift0;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && shift0)
        begin
            s1_reg <= s1_next;
        end
    end

    // line stores: centre row moves up to row above, centre takes the new pixel
    assign wr_data = {s1_reg.px, rd_data[ENTRY_W-1:LINE_W]};

    lbp_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && shift0),
        .rd_addr (rd_addr),
        .wr_en   (s1_go && s1_reg.pixel),
        .wr_addr (s1_reg.addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // window shift: new right column is {row above, centre row, new pixel}
    always_comb
    begin
        win_next[0]    = win_reg[1];
        win_next[1]    = win_reg[2];
        win_next[2][0] = rd_data[LINE_W-1:0];
        win_next[2][1] = rd_data[ENTRY_W-1:LINE_W];
        win_next[2][2] = s1_reg.px;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg_restart)
        begin
            win_reg <= '0;
        end
        else if (s1_go)
        begin
            win_reg <= win_next;
        end
    end

    // one compare lane per channel
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        nbr_t nbrs;

        assign nbrs[0] = win_next[0][0][g*PIX_W +: PIX_W];
        assign nbrs[1] = win_next[0][1][g*PIX_W +: PIX_W];
        assign nbrs[2] = win_next[0][2][g*PIX_W +: PIX_W];
        assign nbrs[3] = win_next[1][0][g*PIX_W +: PIX_W];
        assign nbrs[4] = win_next[1][2][g*PIX_W +: PIX_W];
        assign nbrs[5] = win_next[2][0][g*PIX_W +: PIX_W];
        assign nbrs[6] = win_next[2][1][g*PIX_W +: PIX_W];
        assign nbrs[7] = win_next[2][2][g*PIX_W +: PIX_W];

        lbp_lane u_lane (
            .centre (win_next[1][1][g*PIX_W +: PIX_W]),
            .nbrs   (nbrs),
            .ok     (s1_reg.ok),
            .code   (lane_codes[g])
        );
    end

    // merge and output buffer
    always_comb
    begin
        res.fend  = s1_reg.fend;
        res.row   = s1_reg.row;
        res.col   = s1_reg.col;
        res.codes = lane_codes;
    end

    lbp_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s1_go && s1_reg.emit),
        .res_in   (res),
        .nch      (nch_eff),
        .space    (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // pending results never exceed the frame width plus one
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= (w_eff + FW_W'(1)))
        else $error("pending count beyond frame width plus one");

    // input column stays inside the row
    a_in_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, in_col_reg} < w_eff)
        else $error("input column outside the frame");

    // a drain with nothing pending leaves the read stage empty
    a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_drain && !has_pending) |=> !s1_valid_reg)
        else $error("empty drain entered the read stage");

endmodule
